// File: rtl/sct_pkg.sv
// shared types, constants and character codes of the command tokenizer
package sct_pkg;

    localparam int MAX_TEXT_LEN = 65536;
    localparam int POS_W        = $clog2(MAX_TEXT_LEN + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_BAR    = 8'h7c;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    typedef enum logic [3:0] {
        M_IDLE,
        M_WORD,
        M_WORD_ESC,
        M_SQ,
        M_DQ,
        M_DQ_ESC,
        M_DOLLAR,
        M_DNAME,
        M_BRACE_START,
        M_BRACE_NAME,
        M_COMMENT,
        M_OPER,
        M_ERROR
    } t_mode;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_STRING,
        ERR_VARIABLE,
        ERR_DOLLAR,
        ERR_TOO_LONG
    } t_err;

    typedef struct packed {
        logic [15:0] token_offset;
        logic [15:0] token_length;
        logic        has_special;
        logic        breaks_program;
        t_err        error_code;
        logic        step_last;
        logic        text_done;
    } t_result;

    // results caused by one text byte; res1 is used only when two is set
    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_entry;

endpackage

// File: rtl/sct_front.sv
// front end: scans one text byte per transaction and forms its token reports
module sct_front import sct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_push,
    output t_entry     o_entry
);

    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_step;

    t_mode            r_mode,  n_mode;
    logic             r_qret,  n_qret;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [POS_W-1:0] r_start, n_start;
    logic [7:0]       r_first, n_first;
    logic             r_long,  n_long;
    logic             r_spec,  n_spec;
    logic             r_pend,  n_pend;
    t_step            s_step;

    function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
        logic [POS_W+15:0] w;
        w = (POS_W + 16)'(v);
        return (w > (POS_W + 16)'(16'hffff)) ? 16'hffff : w[15:0];
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_name(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], CH_USCORE};
    endfunction

    function automatic t_result mk_res(input logic [POS_W-1:0] off,
                                       input logic [POS_W-1:0] len,
                                       input logic spec, input logic brk,
                                       input t_err err);
        t_result r;
        r.token_offset   = sat16(off);
        r.token_length   = sat16(len);
        r.has_special    = spec;
        r.breaks_program = brk;
        r.error_code     = err;
        r.step_last      = 1'b0;
        r.text_done      = 1'b0;
        return r;
    endfunction

    // a third report in one step is dropped
    function automatic t_step put(input t_step s, input t_result r);
        t_step o;
        o = s;
        if (s.cnt == 2'd0) begin
            o.res0 = r;
            o.cnt  = 2'd1;
        end else if (s.cnt == 2'd1) begin
            o.res1 = r;
            o.cnt  = 2'd2;
        end
        return o;
    endfunction

    // next state and the reports of this byte
    always_comb begin
        logic             do_tok;
        logic             at_start;
        logic             do_dq;
        logic             do_idle;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] one;
        t_step            st;

        n_mode   = r_mode;
        n_qret   = r_qret;
        n_start  = r_start;
        n_first  = r_first;
        n_long   = r_long;
        n_spec   = r_spec;
        n_pend   = r_pend;
        pos      = r_pos;
        one      = POS_W'(1);
        st       = '0;
        do_tok   = 1'b0;
        at_start = 1'b0;
        do_dq    = 1'b0;
        do_idle  = 1'b0;

        if (r_mode != M_ERROR) begin
            if (r_pos >= POS_W'(MAX_TEXT_LEN)) begin
                st     = put(st, mk_res(pos, '0, 1'b0, 1'b0, ERR_TOO_LONG));
                n_mode = M_ERROR;
            end else begin
                case (r_mode)
                    M_IDLE:     do_idle = 1'b1;
                    M_WORD:     do_tok  = 1'b1;
                    M_WORD_ESC: n_mode  = M_WORD;
                    M_SQ: begin
                        if (i_byte == CH_SQUOTE) n_mode = M_WORD;
                    end
                    M_DQ:       do_dq   = 1'b1;
                    M_DQ_ESC:   n_mode  = M_DQ;
                    M_DOLLAR: begin
                        if (is_name(i_byte)) begin
                            n_mode = M_DNAME;
                        end else if (i_byte == CH_LBRACE) begin
                            n_mode = M_BRACE_START;
                        end else if (i_byte == CH_AT) begin
                            n_mode = r_qret ? M_DQ : M_WORD;
                        end else begin
                            st     = put(st, mk_res(pos, '0, 1'b0, 1'b0, ERR_DOLLAR));
                            n_mode = M_ERROR;
                        end
                    end
                    M_DNAME: begin
                        if (!is_name(i_byte)) begin
                            if (r_qret) begin
                                n_mode = M_DQ;
                                do_dq  = 1'b1;
                            end else begin
                                n_mode = M_WORD;
                                do_tok = 1'b1;
                            end
                        end
                    end
                    M_BRACE_START: begin
                        if (is_name(i_byte)) begin
                            n_mode = M_BRACE_NAME;
                        end else begin
                            st     = put(st, mk_res(pos, '0, 1'b0, 1'b0, ERR_VARIABLE));
                            n_mode = M_ERROR;
                        end
                    end
                    M_BRACE_NAME: begin
                        if (i_byte == CH_RBRACE) begin
                            n_mode = r_qret ? M_DQ : M_WORD;
                        end else if (!is_name(i_byte)) begin
                            st     = put(st, mk_res(pos, '0, 1'b0, 1'b0, ERR_VARIABLE));
                            n_mode = M_ERROR;
                        end
                    end
                    M_COMMENT: begin
                        if (i_byte == CH_NL) do_idle = 1'b1;
                    end
                    M_OPER: begin
                        n_mode = M_IDLE;
                        if (i_byte == (r_pend ? CH_BAR : CH_AMP)) begin
                            st = put(st, mk_res(r_start, POS_W'(2), 1'b1, 1'b1, ERR_NONE));
                        end else begin
                            st      = put(st, mk_res(r_start, one, 1'b1, 1'b1, ERR_NONE));
                            do_idle = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (do_dq) begin
            if (i_byte == CH_BSLASH) begin
                n_mode = M_DQ_ESC;
            end else if (i_byte == CH_DOLLAR) begin
                n_qret = 1'b1;
                n_mode = M_DOLLAR;
            end else if (i_byte == CH_DQUOTE) begin
                n_mode = M_WORD;
            end
        end

        if (do_idle && !is_sep(i_byte)) begin
            n_start  = pos;
            n_first  = i_byte;
            n_long   = 1'b0;
            n_spec   = 1'b0;
            do_tok   = 1'b1;
            at_start = 1'b1;
        end

        if (do_tok) begin
            if (is_sep(i_byte)) begin
                if (!at_start)
                    st = put(st, mk_res(n_start, pos - n_start, n_spec, 1'b0, ERR_NONE));
                n_mode = M_IDLE;
            end else begin
                case (i_byte) inside
                    CH_NL, CH_SEMI, CH_LPAR, CH_RPAR: begin
                        if (!at_start) begin
                            st = put(st, mk_res(n_start, pos - n_start, n_spec, 1'b0,
                                                ERR_NONE));
                            n_start = pos;
                            n_first = i_byte;
                            n_long  = 1'b0;
                            n_spec  = 1'b0;
                        end
                        st     = put(st, mk_res(pos, one, 1'b1, 1'b1, ERR_NONE));
                        n_mode = M_IDLE;
                    end
                    CH_LT, CH_GT: begin
                        // a lone 1 or 2 right before the arrow forms a redirection
                        if (!at_start && !n_long && !n_spec &&
                            (n_first == CH_ONE || n_first == CH_TWO)) begin
                            st = put(st, mk_res(n_start, POS_W'(2), 1'b1, 1'b0, ERR_NONE));
                        end else begin
                            if (!at_start) begin
                                st = put(st, mk_res(n_start, pos - n_start, n_spec, 1'b0,
                                                    ERR_NONE));
                                n_start = pos;
                                n_first = i_byte;
                                n_long  = 1'b0;
                                n_spec  = 1'b0;
                            end
                            st = put(st, mk_res(pos, one, 1'b1, 1'b0, ERR_NONE));
                        end
                        n_mode = M_IDLE;
                    end
                    CH_AMP, CH_BAR: begin
                        if (!at_start) begin
                            st = put(st, mk_res(n_start, pos - n_start, n_spec, 1'b0,
                                                ERR_NONE));
                            n_start = pos;
                            n_first = i_byte;
                            n_long  = 1'b0;
                            n_spec  = 1'b0;
                        end
                        n_pend = (i_byte != CH_AMP);
                        n_mode = M_OPER;
                    end
                    CH_HASH:   n_mode = at_start ? M_COMMENT : M_WORD;
                    CH_SQUOTE: begin
                        n_spec = 1'b1;
                        n_mode = M_SQ;
                    end
                    CH_DQUOTE: begin
                        n_spec = 1'b1;
                        n_mode = M_DQ;
                    end
                    CH_DOLLAR: begin
                        n_spec = 1'b1;
                        n_qret = 1'b0;
                        n_mode = M_DOLLAR;
                    end
                    CH_BSLASH: n_mode = M_WORD_ESC;
                    default:   n_mode = M_WORD;
                endcase
            end
        end

        n_pos = (r_pos < POS_W'(MAX_TEXT_LEN)) ? r_pos + one : r_pos;

        if (!(n_mode inside {M_IDLE, M_COMMENT, M_ERROR, M_OPER}) && pos != n_start)
            n_long = 1'b1;

        // end of text: close what is open, then start over
        if (i_end) begin
            case (n_mode)
                M_WORD, M_WORD_ESC: begin
                    st = put(st, mk_res(n_start, pos + one - n_start, n_spec, 1'b0,
                                        ERR_NONE));
                end
                M_DOLLAR, M_DNAME: begin
                    if (n_qret)
                        st = put(st, mk_res(pos, '0, 1'b0, 1'b0, ERR_STRING));
                    else
                        st = put(st, mk_res(n_start, pos + one - n_start, n_spec, 1'b0,
                                            ERR_NONE));
                end
                M_SQ, M_DQ, M_DQ_ESC: st = put(st, mk_res(pos, '0, 1'b0, 1'b0, ERR_STRING));
                M_BRACE_START, M_BRACE_NAME: begin
                    st = put(st, mk_res(pos, '0, 1'b0, 1'b0, ERR_VARIABLE));
                end
                M_OPER: st = put(st, mk_res(n_start, one, 1'b1, 1'b1, ERR_NONE));
                default: ;
            endcase
            if (st.cnt == 2'd0)
                st = put(st, mk_res(pos, '0, 1'b0, 1'b0, ERR_NONE));
            if (st.cnt == 2'd1)
                st.res0.text_done = 1'b1;
            else
                st.res1.text_done = 1'b1;
            n_mode  = M_IDLE;
            n_qret  = 1'b0;
            n_pos   = '0;
            n_start = '0;
            n_first = '0;
            n_long  = 1'b0;
            n_spec  = 1'b0;
            n_pend  = 1'b0;
        end

        s_step = st;
    end

    // queue entry for this byte
    always_comb begin
        o_entry.two  = (s_step.cnt == 2'd2);
        o_entry.res0 = s_step.res0;
        o_entry.res1 = s_step.res1;
        if (s_step.cnt == 2'd2)
            o_entry.res1.step_last = 1'b1;
        else
            o_entry.res0.step_last = 1'b1;
        o_push = i_accept && (s_step.cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_qret  <= 1'b0;
            r_pos   <= '0;
            r_start <= '0;
            r_first <= '0;
            r_long  <= 1'b0;
            r_spec  <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_qret  <= n_qret;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_first <= n_first;
            r_long  <= n_long;
            r_spec  <= n_spec;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: rtl/sct_queue.sv
// short queue of per-byte report entries between front and back
module sct_queue import sct_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (i_push && !i_pop)
                r_count <= r_count + (QPTR_W + 1)'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - (QPTR_W + 1)'(1);
        end
    end

endmodule

// File: rtl/sct_back.sv
// back end: splits queue entries into single reports behind an output register
module sct_back import sct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_entry  i_entry,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic    r_out_v;
    logic    r_pend_v;
    t_result r_out;
    t_result r_pend;
    logic    out_free;

    assign out_free = !r_out_v || i_ready;
    // second report of an entry goes out before the next entry is taken
    assign o_pop    = i_valid && !r_pend_v && out_free;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (out_free) begin
            if (r_pend_v) begin
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end else if (i_valid) begin
                r_out_v  <= 1'b1;
                r_pend_v <= i_entry.two;
            end else begin
                r_out_v  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_v) begin
                r_out <= r_pend;
            end else if (i_valid) begin
                r_out  <= i_entry.res0;
                r_pend <= i_entry.res1;
            end
        end
    end

endmodule

// File: rtl/shell_command_tokenizer.sv
// top level of the shell command tokenizer
//
// Input stream: one byte of command text per transaction, tlast on the last
// byte of a text. Output stream: one token report per transaction, tlast on
// the final report of a text. A byte yields zero, one or two reports.
//
// The front end scans a byte in the cycle it is accepted and writes its
// reports as one entry into a four-entry queue; the back end takes entries
// from the queue and presents the reports one at a time from an output
// register. Throughput is one byte per cycle while bytes yield at most one
// report and the receiver is ready; a byte with two reports holds the
// output until both have gone out, so sustained rate is set by the
// single-report output register once the queue has filled.
// When the receiver stalls, the report on the output holds and the queue
// absorbs up to four more entries before s_axis_tready drops.
// Reset (synchronous, active low) empties queue and output and puts the
// scanner between tokens at byte position zero. After an error, bytes are
// dropped until the end of that text.
module shell_command_tokenizer import sct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // text_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] token_offset, [31:16] token_length
    output logic [5:0]  m_axis_tuser,   // [0] has_special, [1] breaks_program,
                                        // [4:2] error_code, [5] step_last
    output logic        m_axis_tlast    // text_done
);

    logic    in_accept;
    logic    q_push;
    t_entry  q_in;
    logic    q_valid;
    t_entry  q_out;
    logic    q_pop;
    t_result res;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    sct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    sct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_ready (s_axis_tready),
        .o_valid (q_valid),
        .o_entry (q_out),
        .i_pop   (q_pop)
    );

    sct_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_out),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .o_result (res),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {res.token_length, res.token_offset};
    assign m_axis_tuser = {res.step_last, res.error_code, res.breaks_program,
                           res.has_special};
    assign m_axis_tlast = res.text_done;

endmodule

// File: rtl/sct_checker.sv
// port checks of the shell command tokenizer, bound to the top level
module sct_checker import sct_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,   // [15:0] token_offset, [31:16] token_length
    input logic [5:0]  m_axis_tuser,   // [0] has_special, [1] breaks_program,
                                       // [4:2] error_code, [5] step_last
    input logic        m_axis_tlast    // text_done
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("report withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("report changed while stalled");

    // an error report carries no length and no flags
    a_error_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4:2] != ERR_NONE |->
            m_axis_tdata[31:16] == 16'd0 && m_axis_tuser[1:0] == 2'b00)
        else $error("error report with length or flags");

    // the final report of a text is also the last report of its byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[5])
        else $error("text done without step last");

    a_break_special: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("program break without special flag");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
